FILE: hw/rtl/version_bits_deployment_tracker_defines.svh
// Assertion macros for the deployment tracker.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef VERSION_BITS_DEPLOYMENT_TRACKER_DEFINES_SVH
`define VERSION_BITS_DEPLOYMENT_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VBDT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VBDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VBDT_ASSERT_SAME(label, ante, cons, msg)
`define VBDT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/vbdt_pkg.sv
// Shared types and constants of the deployment tracker.
// No dependencies.
package vbdt_pkg;

  typedef enum logic [2:0] {
    ST_DEFINED = 3'd0,
    ST_STARTED = 3'd1,
    ST_LOCKED  = 3'd2,
    ST_ACTIVE  = 3'd3,
    ST_FAILED  = 3'd4
  } state_t;

  localparam logic [2:0]  VER_TOP_FIELD  = 3'b001;
  localparam logic [31:0] TEMPLATE_BASE  = 32'h2000_0000;
  localparam logic [15:0] PERIOD_RESET   = 16'd2016;
  localparam logic [15:0] THRESH_RESET   = 16'd1916;
  localparam logic [31:0] TIMEOUT_RESET  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] period_length;
    logic [15:0] lock_threshold;
    logic [4:0]  signal_bit;
    logic [31:0] start_mtp;
    logic [31:0] timeout_time;
  } cfg_t;

  typedef struct packed {
    state_t      deploy_state;
    logic [15:0] period_position;
    logic [15:0] signal_tally;
    logic [31:0] block_height;
    logic [31:0] state_since;
  } track_t;

  typedef struct packed {
    logic [31:0] header_version;
    logic [31:0] median_time;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  next_state;
    logic        block_signals;
    logic        period_end;
    logic [15:0] elapsed_in_period;
    logic [15:0] period_signal_count;
    logic        lock_possible;
    logic [31:0] since_height;
    logic [31:0] version_template;
  } res_t;

endpackage

FILE: hw/rtl/vbdt_in_if.sv
// Header input channel: valid/ready handshake with one header per beat.
// No dependencies.
interface vbdt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_version;
  logic [31:0] median_time;

  modport source (output valid, output header_version, output median_time, input ready);
  modport sink (input valid, input header_version, input median_time, output ready);
endinterface

FILE: hw/rtl/vbdt_out_if.sv
// Result output channel: valid/ready handshake with one result per beat.
// No dependencies.
interface vbdt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  next_state;
  logic        block_signals;
  logic        period_end;
  logic [15:0] elapsed_in_period;
  logic [15:0] period_signal_count;
  logic        lock_possible;
  logic [31:0] since_height;
  logic [31:0] version_template;

  modport source (
    output valid, output next_state, output block_signals, output period_end,
    output elapsed_in_period, output period_signal_count, output lock_possible,
    output since_height, output version_template, input ready
  );
  modport sink (
    input valid, input next_state, input block_signals, input period_end,
    input elapsed_in_period, input period_signal_count, input lock_possible,
    input since_height, input version_template, output ready
  );
endinterface

FILE: hw/rtl/vbdt_eval.sv
// Per-header evaluation: signal test, period counters, state decision, result.
// Depends on vbdt_pkg.
module vbdt_eval (
  input  vbdt_pkg::cfg_t   cfg,
  input  vbdt_pkg::track_t cur,
  input  vbdt_pkg::hdr_t   hdr,
  output vbdt_pkg::track_t nxt,
  output vbdt_pkg::res_t   res
);
  import vbdt_pkg::*;

  logic        sig;
  logic [16:0] pos_sum;
  logic [15:0] tally_sum;
  logic        last;
  state_t      decided;
  logic [31:0] since_new;
  logic [17:0] slack;
  logic [17:0] missed;

  always_comb begin
    sig = (hdr.header_version[31:29] == VER_TOP_FIELD) && hdr.header_version[cfg.signal_bit];
    pos_sum = {1'b0, cur.period_position} + 17'd1;
    tally_sum = cur.signal_tally + {15'd0, sig};
    last = pos_sum >= {1'b0, cfg.period_length};

    if (hdr.median_time < cfg.start_mtp) begin
      decided = ST_DEFINED;
    end else begin
      case (cur.deploy_state)
        ST_DEFINED: begin
          decided = (hdr.median_time >= cfg.timeout_time) ? ST_FAILED : ST_STARTED;
        end
        ST_STARTED: begin
          if (hdr.median_time >= cfg.timeout_time) begin
            decided = ST_FAILED;
          end else if (tally_sum >= cfg.lock_threshold) begin
            decided = ST_LOCKED;
          end else begin
            decided = ST_STARTED;
          end
        end
        ST_LOCKED: decided = ST_ACTIVE;
        ST_ACTIVE: decided = ST_ACTIVE;
        default:   decided = ST_FAILED;
      endcase
    end

    since_new = (&cur.block_height) ? cur.block_height : cur.block_height + 32'd1;

    nxt = cur;
    nxt.block_height = since_new;
    if (last) begin
      nxt.deploy_state = decided;
      nxt.period_position = 16'd0;
      nxt.signal_tally = 16'd0;
      if (decided != cur.deploy_state) begin
        nxt.state_since = (decided == ST_DEFINED) ? 32'd0 : since_new;
      end
    end else begin
      nxt.period_position = pos_sum[15:0];
      nxt.signal_tally = tally_sum;
    end

    slack = {2'b00, cfg.period_length} - {2'b00, cfg.lock_threshold};
    missed = {2'b00, nxt.period_position} - {2'b00, nxt.signal_tally};

    res.next_state = nxt.deploy_state;
    res.block_signals = sig;
    res.period_end = last;
    res.elapsed_in_period = nxt.period_position;
    res.period_signal_count = nxt.signal_tally;
    res.lock_possible = $signed(slack) >= $signed(missed);
    res.since_height = (nxt.deploy_state == ST_DEFINED) ? 32'd0 : nxt.state_since;
    res.version_template = TEMPLATE_BASE;
    if (nxt.deploy_state == ST_STARTED || nxt.deploy_state == ST_LOCKED) begin
      res.version_template = TEMPLATE_BASE | (32'd1 << cfg.signal_bit);
    end
  end

endmodule

FILE: hw/rtl/version_bits_deployment_tracker.sv
// Top level of the version-bits deployment tracker: APB registers, header
// register, tracking state and result register. Depends on vbdt_pkg,
// vbdt_in_if, vbdt_out_if, vbdt_eval and the assertion macro header.
//
// Usage:
//   in_ch  takes block headers of one chain in height order, genesis first,
//          one header per beat (version word and median time past).
//   out_ch gives one result per header: state for the following block,
//          signal flag, period statistics, since-height and version template.
//   cfg_*  APB registers at byte address 4*i: period_length, lock_threshold,
//          signal_bit, start_time, timeout_time. Write only while idle.
// Timing:
//   A taken header is held in the header register, evaluated from it, and
//   its result is loaded into the result register; one header per cycle
//   sustained while out_ch does not stall. The tracking state updates
//   in the same cycle the result register loads.
// Reset puts the deployment in defined at height 0, clears the counters and
// restores the register defaults. When out_ch stalls, the result holds, one
// more header waits in the header register, then in_ch.ready drops.
`include "version_bits_deployment_tracker_defines.svh"
module version_bits_deployment_tracker (
  input  logic               clk,
  input  logic               rst_n,
  vbdt_in_if.sink            in_ch,
  vbdt_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import vbdt_pkg::*;

  localparam logic [2:0] REG_PERIOD  = 3'd0;
  localparam logic [2:0] REG_THRESH  = 3'd1;
  localparam logic [2:0] REG_BIT     = 3'd2;
  localparam logic [2:0] REG_START   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  cfg_t   cfg_r;
  track_t track_r;
  track_t track_nxt;
  hdr_t   hdr_r;
  res_t   res_r;
  res_t   res_nxt;
  logic   s1_valid_r;
  logic   out_valid_r;
  logic   advance;
  logic   in_ready;
  logic   cfg_wr;
  logic   step;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;
  assign step     = advance && s1_valid_r;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;

  vbdt_eval u_eval (
    .cfg (cfg_r),
    .cur (track_r),
    .hdr (hdr_r),
    .nxt (track_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      track_r <= '{deploy_state: ST_DEFINED, period_position: 16'd0, signal_tally: 16'd0,
                   block_height: 32'd0, state_since: 32'd0};
      cfg_r <= '{period_length: PERIOD_RESET, lock_threshold: THRESH_RESET,
                 signal_bit: 5'd0, start_mtp: 32'd0, timeout_time: TIMEOUT_RESET};
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        track_r <= track_nxt;
      end
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_PERIOD:  cfg_r.period_length <= cfg_pwdata[15:0];
          REG_THRESH:  cfg_r.lock_threshold <= cfg_pwdata[15:0];
          REG_BIT:     cfg_r.signal_bit <= cfg_pwdata[4:0];
          REG_START:   cfg_r.start_mtp <= cfg_pwdata;
          REG_TIMEOUT: cfg_r.timeout_time <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      hdr_r <= '{header_version: in_ch.header_version, median_time: in_ch.median_time};
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_PERIOD:  cfg_prdata = {16'd0, cfg_r.period_length};
      REG_THRESH:  cfg_prdata = {16'd0, cfg_r.lock_threshold};
      REG_BIT:     cfg_prdata = {27'd0, cfg_r.signal_bit};
      REG_START:   cfg_prdata = cfg_r.start_mtp;
      REG_TIMEOUT: cfg_prdata = cfg_r.timeout_time;
      default:     cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_ch.ready = in_ready;

  assign out_ch.valid               = out_valid_r;
  assign out_ch.next_state          = res_r.next_state;
  assign out_ch.block_signals       = res_r.block_signals;
  assign out_ch.period_end          = res_r.period_end;
  assign out_ch.elapsed_in_period   = res_r.elapsed_in_period;
  assign out_ch.period_signal_count = res_r.period_signal_count;
  assign out_ch.lock_possible       = res_r.lock_possible;
  assign out_ch.since_height        = res_r.since_height;
  assign out_ch.version_template    = res_r.version_template;

  `VBDT_ASSERT_NEXT(a_hdr_held, s1_valid_r && !advance,
    s1_valid_r && $stable(hdr_r), "stalled header lost")
  `VBDT_ASSERT_NEXT(a_state_at_end,
    step && !track_nxt.period_position[0] && !res_nxt.period_end,
    $stable(track_r.deploy_state), "state moved mid-period")
  `VBDT_ASSERT_NEXT(a_height_moves, step, track_r.block_height != 32'd0,
    "height did not advance")
  `VBDT_ASSERT_SAME(a_end_clears, out_valid_r && res_r.period_end,
    res_r.elapsed_in_period == 16'd0 && res_r.period_signal_count == 16'd0,
    "period end without counter clear")
  `VBDT_ASSERT_SAME(a_count_le_elapsed, out_valid_r,
    res_r.period_signal_count <= res_r.elapsed_in_period, "signal count above elapsed")

endmodule
